@@ rtl/kft_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kft_pkg
// Shared types, codes and the operation program of the three-axis tracker.
// ----------------------------------------------------------------------------
package kft_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int REQ_W         = 2;
    localparam int NUM_AXES      = 3;
    localparam int NUM_EST       = 2 * NUM_AXES;
    localparam int RAM_DEPTH     = 64;
    localparam int RAM_AW        = 6;
    localparam int PC_W          = 6;
    localparam int CODE_W        = 6;
    localparam int FILL_W        = 5;
    localparam int FILL_LAST     = 8 * NUM_AXES - 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_VAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL_VAR = 3'd4;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_PREDICT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CORRECT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REINIT  = 2'd2;

    // operand codes: below 8 is a slot of the current axis
    localparam logic [CODE_W-1:0] C_POS   = 6'd0;
    localparam logic [CODE_W-1:0] C_VEL   = 6'd1;
    localparam logic [CODE_W-1:0] C_P00   = 6'd2;
    localparam logic [CODE_W-1:0] C_P01   = 6'd3;
    localparam logic [CODE_W-1:0] C_P11   = 6'd4;
    localparam logic [CODE_W-1:0] C_DT    = 6'd24;
    localparam logic [CODE_W-1:0] C_S     = 6'd25;
    localparam logic [CODE_W-1:0] C_R     = 6'd26;
    localparam logic [CODE_W-1:0] C_THIRD = 6'd27;
    localparam logic [CODE_W-1:0] C_HALF  = 6'd28;
    localparam logic [CODE_W-1:0] C_ZP    = 6'd30;
    localparam logic [CODE_W-1:0] C_ZV    = 6'd31;
    localparam logic [CODE_W-1:0] C_T0    = 6'd32;
    localparam logic [CODE_W-1:0] C_T1    = 6'd33;
    localparam logic [CODE_W-1:0] C_T2    = 6'd34;
    localparam logic [CODE_W-1:0] C_T3    = 6'd35;
    localparam logic [CODE_W-1:0] C_T4    = 6'd36;
    localparam logic [CODE_W-1:0] C_T5    = 6'd37;
    localparam logic [CODE_W-1:0] C_T6    = 6'd38;
    localparam logic [CODE_W-1:0] C_T7    = 6'd39;
    localparam logic [CODE_W-1:0] C_T8    = 6'd40;
    localparam logic [CODE_W-1:0] C_T9    = 6'd41;
    localparam logic [CODE_W-1:0] C_T10   = 6'd42;
    localparam logic [CODE_W-1:0] C_T11   = 6'd43;
    localparam logic [CODE_W-1:0] C_T12   = 6'd44;

    localparam logic [PC_W-1:0] PRED_BASE = 6'd0;
    localparam logic [PC_W-1:0] CORR_BASE = 6'd18;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [CODE_W-1:0] dst;
        logic [CODE_W-1:0] src_a;
        logic [CODE_W-1:0] src_b;
        logic              last;
    } uop_t;

    typedef struct packed {
        logic               start;
        alu_op_t            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] result;
        logic               sat;
    } alu_rsp_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } clip_t;

    function automatic clip_t clip64(input logic signed [63:0] v);
        clip_t r;
        if (v > 64'sd2147483647) begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
        end else if (v < -64'sd2147483648) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic uop_t mk(input alu_op_t op, input logic [CODE_W-1:0] d,
                                input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                                input logic last);
        uop_t u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        u.last  = last;
        return u;
    endfunction

    // predict program from PRED_BASE, correct program from CORR_BASE
    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:  u = mk(OP_MUL, C_T0,  C_DT,  C_DT,  1'b0);
            6'd1:  u = mk(OP_MUL, C_T1,  C_T0,  C_DT,  1'b0);
            6'd2:  u = mk(OP_MUL, C_T2,  C_DT,  C_VEL, 1'b0);
            6'd3:  u = mk(OP_ADD, C_POS, C_POS, C_T2,  1'b0);
            6'd4:  u = mk(OP_MUL, C_T2,  C_DT,  C_P11, 1'b0);
            6'd5:  u = mk(OP_ADD, C_T3,  C_P01, C_T2,  1'b0);
            6'd6:  u = mk(OP_MUL, C_T2,  C_DT,  C_P01, 1'b0);
            6'd7:  u = mk(OP_ADD, C_T4,  C_P00, C_T2,  1'b0);
            6'd8:  u = mk(OP_MUL, C_T2,  C_DT,  C_T3,  1'b0);
            6'd9:  u = mk(OP_ADD, C_P00, C_T4,  C_T2,  1'b0);
            6'd10: u = mk(OP_MUL, C_T2,  C_S,   C_THIRD, 1'b0);
            6'd11: u = mk(OP_MUL, C_T2,  C_T2,  C_T1,  1'b0);
            6'd12: u = mk(OP_ADD, C_P00, C_P00, C_T2,  1'b0);
            6'd13: u = mk(OP_MUL, C_T2,  C_S,   C_HALF, 1'b0);
            6'd14: u = mk(OP_MUL, C_T2,  C_T2,  C_T0,  1'b0);
            6'd15: u = mk(OP_ADD, C_P01, C_T3,  C_T2,  1'b0);
            6'd16: u = mk(OP_MUL, C_T2,  C_S,   C_DT,  1'b0);
            6'd17: u = mk(OP_ADD, C_P11, C_P11, C_T2,  1'b1);
            6'd18: u = mk(OP_ADD, C_T0,  C_P00, C_R,   1'b0);
            6'd19: u = mk(OP_ADD, C_T1,  C_P11, C_R,   1'b0);
            6'd20: u = mk(OP_MUL, C_T2,  C_P01, C_P01, 1'b0);
            6'd21: u = mk(OP_MUL, C_T3,  C_T0,  C_T1,  1'b0);
            6'd22: u = mk(OP_SUB, C_T3,  C_T3,  C_T2,  1'b0);
            6'd23: u = mk(OP_MUL, C_T4,  C_P00, C_T1,  1'b0);
            6'd24: u = mk(OP_SUB, C_T4,  C_T4,  C_T2,  1'b0);
            6'd25: u = mk(OP_DIV, C_T4,  C_T4,  C_T3,  1'b0);
            6'd26: u = mk(OP_MUL, C_T5,  C_P01, C_R,   1'b0);
            6'd27: u = mk(OP_DIV, C_T5,  C_T5,  C_T3,  1'b0);
            6'd28: u = mk(OP_MUL, C_T6,  C_P11, C_T0,  1'b0);
            6'd29: u = mk(OP_SUB, C_T6,  C_T6,  C_T2,  1'b0);
            6'd30: u = mk(OP_DIV, C_T6,  C_T6,  C_T3,  1'b0);
            6'd31: u = mk(OP_SUB, C_T7,  C_ZP,  C_POS, 1'b0);
            6'd32: u = mk(OP_SUB, C_T8,  C_ZV,  C_VEL, 1'b0);
            6'd33: u = mk(OP_MUL, C_T9,  C_T4,  C_T7,  1'b0);
            6'd34: u = mk(OP_MUL, C_T10, C_T5,  C_T8,  1'b0);
            6'd35: u = mk(OP_ADD, C_T9,  C_T9,  C_T10, 1'b0);
            6'd36: u = mk(OP_ADD, C_POS, C_POS, C_T9,  1'b0);
            6'd37: u = mk(OP_MUL, C_T9,  C_T5,  C_T7,  1'b0);
            6'd38: u = mk(OP_MUL, C_T10, C_T6,  C_T8,  1'b0);
            6'd39: u = mk(OP_ADD, C_T9,  C_T9,  C_T10, 1'b0);
            6'd40: u = mk(OP_ADD, C_VEL, C_VEL, C_T9,  1'b0);
            6'd41: u = mk(OP_MUL, C_T9,  C_T4,  C_P00, 1'b0);
            6'd42: u = mk(OP_MUL, C_T10, C_T5,  C_P01, 1'b0);
            6'd43: u = mk(OP_ADD, C_T9,  C_T9,  C_T10, 1'b0);
            6'd44: u = mk(OP_MUL, C_T10, C_T4,  C_P01, 1'b0);
            6'd45: u = mk(OP_MUL, C_T11, C_T5,  C_P11, 1'b0);
            6'd46: u = mk(OP_ADD, C_T10, C_T10, C_T11, 1'b0);
            6'd47: u = mk(OP_MUL, C_T11, C_T5,  C_P01, 1'b0);
            6'd48: u = mk(OP_MUL, C_T12, C_T6,  C_P11, 1'b0);
            6'd49: u = mk(OP_ADD, C_T11, C_T11, C_T12, 1'b0);
            6'd50: u = mk(OP_SUB, C_P00, C_P00, C_T9,  1'b0);
            6'd51: u = mk(OP_SUB, C_P01, C_P01, C_T10, 1'b0);
            6'd52: u = mk(OP_SUB, C_P11, C_P11, C_T11, 1'b1);
            default: u = mk(OP_ADD, C_T12, C_T12, C_T12, 1'b1);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

@@ rtl/three_axis_kalman_tracker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_kalman_tracker
// Constant-velocity Kalman tracker for three axes in signed fixed point.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------------
//   s_      | in  | s_tvalid / s_tready  | tuser req_type, tdata measurements
//   m_      | out | m_tvalid / m_tready  | tdata estimates, tuser saturated
//   cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Each op runs FETCH, EXEC, then waits on the shared unit. Predict and correct
// run their program once per axis, reinit reruns the clearing pass; each word
// then passes DONE and IDLE.
// After reset a clearing pass loads the covariance; no word is taken then.
// The result register holds while m_tready is low; the next word is taken,
// and its result waits in DONE until the register drains.
// ----------------------------------------------------------------------------
module three_axis_kalman_tracker #(
    parameter int FRAC_BITS = kft_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // meas_pos_x, meas_vel_x, meas_pos_y, meas_vel_y, meas_pos_z, meas_vel_z
    input  wire logic [6*32-1:0]                 s_tdata,
    // req_type
    input  wire logic [kft_pkg::REQ_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // est_pos_x, est_vel_x, est_pos_y, est_vel_y, est_pos_z, est_vel_z
    output logic [6*32-1:0]                      m_tdata,
    // saturated
    output logic                                 m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                     cfg_data
);

    localparam logic [31:0] Q_ONE   = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] Q_HALF  = 32'(64'd1 << (FRAC_BITS - 1));
    localparam logic [31:0] Q_THIRD = 32'(((64'd3333 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [30:0] Q_TENTH = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_EXEC  = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [kft_pkg::PC_W-1:0]        pc_reg;
    logic [1:0]                      axis_reg;
    logic [kft_pkg::FILL_W-1:0]      fill_cnt_reg;
    logic                            fill_init_reg;
    logic [kft_pkg::REQ_W-1:0]       req_reg;
    logic [6*32-1:0]                 meas_reg;
    logic                            sat_acc_reg;
    logic [31:0]                     est_reg [kft_pkg::NUM_EST];
    logic [6*32-1:0]                 out_data_reg;
    logic                            out_sat_reg;
    logic                            out_full_reg;
    logic [31:0]                     spec_a_reg, spec_b_reg;
    logic                            ram_a_reg, ram_b_reg;
    logic [30:0]                     time_step_reg, proc_noise_reg, meas_noise_reg;
    logic [30:0]                     init_pos_reg, init_vel_reg;

    kft_pkg::uop_t                   uop;
    kft_pkg::alu_req_t               alu_req;
    kft_pkg::alu_rsp_t               alu_rsp;
    logic                            ram_we;
    logic [kft_pkg::RAM_AW-1:0]      ram_waddr, raddr_a, raddr_b;
    logic [31:0]                     ram_wdata, rdata_a, rdata_b;
    logic [31:0]                     fill_val;
    logic                            s_acc, out_load;
    logic [2:0]                      est_idx;

    function automatic logic [kft_pkg::RAM_AW-1:0] phys(input logic [kft_pkg::CODE_W-1:0] c,
                                                        input logic [1:0] ax);
        if (c < 6'd8) begin
            return {1'b0, ax, c[2:0]};
        end
        return c;
    endfunction

    function automatic logic is_ram(input logic [kft_pkg::CODE_W-1:0] c);
        return (c < kft_pkg::C_DT) || (c >= kft_pkg::C_T0);
    endfunction

    function automatic logic [31:0] spec_val(input logic [kft_pkg::CODE_W-1:0] c,
                                             input logic [30:0] dt, input logic [30:0] s,
                                             input logic [30:0] r, input logic [63:0] z);
        logic [31:0] v;
        unique case (c)
            kft_pkg::C_DT:    v = {1'b0, dt};
            kft_pkg::C_S:     v = {1'b0, s};
            kft_pkg::C_R:     v = {1'b0, r};
            kft_pkg::C_THIRD: v = Q_THIRD;
            kft_pkg::C_HALF:  v = Q_HALF;
            kft_pkg::C_ZP:    v = z[31:0];
            kft_pkg::C_ZV:    v = z[63:32];
            default:          v = 32'd0;
        endcase
        return v;
    endfunction

    assign uop       = kft_pkg::uop_rom(pc_reg);
    assign raddr_a   = phys(uop.src_a, axis_reg);
    assign raddr_b   = phys(uop.src_b, axis_reg);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_full_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_sat_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_full_reg || m_tready);
    assign est_idx   = 3'({axis_reg, 1'b0}) + 3'(uop.dst[0]);

    always_comb begin
        unique case (fill_cnt_reg[2:0])
            3'd2:    fill_val = fill_init_reg ? {1'b0, init_pos_reg} : Q_ONE;
            3'd4:    fill_val = fill_init_reg ? {1'b0, init_vel_reg} : Q_ONE;
            default: fill_val = 32'd0;
        endcase
    end

    always_comb begin
        alu_req.start = (state_reg == ST_EXEC);
        alu_req.op    = uop.op;
        alu_req.a     = ram_a_reg ? rdata_a : spec_a_reg;
        alu_req.b     = ram_b_reg ? rdata_b : spec_b_reg;
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = {1'b0, fill_cnt_reg};
            ram_wdata = fill_val;
        end else begin
            ram_we    = (state_reg == ST_WAIT) && alu_rsp.done;
            ram_waddr = phys(uop.dst, axis_reg);
            ram_wdata = alu_rsp.result;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (fill_cnt_reg == kft_pkg::FILL_W'(kft_pkg::FILL_LAST)) begin
                    state_next = fill_init_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_tuser) inside
                        kft_pkg::REQ_PREDICT, kft_pkg::REQ_CORRECT: state_next = ST_FETCH;
                        kft_pkg::REQ_REINIT: state_next = ST_CLEAR;
                        default:             state_next = ST_DONE;
                    endcase
                end
            end
            ST_FETCH: state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_WAIT;
            ST_WAIT: begin
                if (alu_rsp.done) begin
                    if (uop.last && axis_reg == 2'd2) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            fill_cnt_reg   <= '0;
            fill_init_reg  <= 1'b0;
            out_full_reg   <= 1'b0;
            time_step_reg  <= 31'd0;
            proc_noise_reg <= Q_TENTH;
            meas_noise_reg <= Q_ONE[30:0];
            init_pos_reg   <= Q_ONE[30:0];
            init_vel_reg   <= Q_ONE[30:0];
            for (int i = 0; i < kft_pkg::NUM_EST; i++) begin
                est_reg[i] <= 32'd0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    kft_pkg::REG_TIME_STEP:    time_step_reg  <= cfg_data[30:0];
                    kft_pkg::REG_PROC_NOISE:   proc_noise_reg <= cfg_data[30:0];
                    kft_pkg::REG_MEAS_NOISE:   meas_noise_reg <= cfg_data[30:0];
                    kft_pkg::REG_INIT_POS_VAR: init_pos_reg   <= cfg_data[30:0];
                    kft_pkg::REG_INIT_VEL_VAR: init_vel_reg   <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_CLEAR) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end

            if (s_acc) begin
                meas_reg    <= s_tdata;
                req_reg     <= s_tuser;
                sat_acc_reg <= 1'b0;
                axis_reg    <= 2'd0;
                pc_reg      <= (s_tuser == kft_pkg::REQ_CORRECT) ? kft_pkg::CORR_BASE
                                                                 : kft_pkg::PRED_BASE;
                if (s_tuser == kft_pkg::REQ_REINIT) begin
                    fill_cnt_reg  <= '0;
                    fill_init_reg <= 1'b1;
                    for (int i = 0; i < kft_pkg::NUM_EST; i++) begin
                        est_reg[i] <= 32'd0;
                    end
                end
            end

            if (state_reg == ST_FETCH) begin
                spec_a_reg <= spec_val(uop.src_a, time_step_reg, proc_noise_reg,
                                       meas_noise_reg, meas_reg[63:0]);
                spec_b_reg <= spec_val(uop.src_b, time_step_reg, proc_noise_reg,
                                       meas_noise_reg, meas_reg[63:0]);
                ram_a_reg  <= is_ram(uop.src_a);
                ram_b_reg  <= is_ram(uop.src_b);
            end

            if (state_reg == ST_WAIT && alu_rsp.done) begin
                sat_acc_reg <= sat_acc_reg | alu_rsp.sat;
                if (uop.dst == kft_pkg::C_POS || uop.dst == kft_pkg::C_VEL) begin
                    est_reg[est_idx] <= alu_rsp.result;
                end
                if (uop.last) begin
                    axis_reg <= axis_reg + 1'b1;
                    meas_reg <= {64'd0, meas_reg[6*32-1:64]};
                    pc_reg   <= (req_reg == kft_pkg::REQ_CORRECT) ? kft_pkg::CORR_BASE
                                                                  : kft_pkg::PRED_BASE;
                end else begin
                    pc_reg <= pc_reg + 1'b1;
                end
            end

            if (out_load) begin
                out_full_reg <= 1'b1;
                out_sat_reg  <= sat_acc_reg;
                out_data_reg <= {est_reg[5], est_reg[4], est_reg[3],
                                 est_reg[2], est_reg[1], est_reg[0]};
            end else if (m_tvalid && m_tready) begin
                out_full_reg <= 1'b0;
            end
        end
    end

    kft_ram #(
        .WIDTH (32),
        .DEPTH (kft_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    kft_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

endmodule
`default_nettype wire

@@ rtl/kft_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kft_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

@@ rtl/kft_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kft_alu
// Shared saturating fixed-point unit: add, subtract, rounded multiply and a
// bit-serial restoring divide.
// ----------------------------------------------------------------------------
module kft_alu #(
    parameter int FRAC_BITS = kft_pkg::FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kft_pkg::alu_req_t req,
    output kft_pkg::alu_rsp_t      rsp
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        ALU_IDLE = 3'b001,
        ALU_MUL  = 3'b010,
        ALU_DIV  = 3'b100
    } alu_state_t;

    alu_state_t         st_reg;
    logic signed [63:0] prod_reg;
    logic [DW-1:0]      dvd_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dmag_reg;
    logic               neg_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [31:0] res_reg;
    logic               sat_reg;
    logic               done_reg;

    logic signed [63:0] sum_ext;
    logic signed [63:0] rnd;
    logic signed [63:0] prod;
    kft_pkg::clip_t     sum_clip;
    kft_pkg::clip_t     mul_clip;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [31:0]        rem_new;
    logic [DW-1:0]      dvd_new;
    logic [63:0]        q64;
    logic [31:0]        nmag;
    logic [31:0]        bmag;

    assign prod = req.a * req.b;

    always_comb begin
        if (req.op == kft_pkg::OP_SUB) begin
            sum_ext = 64'(req.a) - 64'(req.b);
        end else begin
            sum_ext = 64'(req.a) + 64'(req.b);
        end
        sum_clip = kft_pkg::clip64(sum_ext);
        rnd      = prod_reg + HALF;
        mul_clip = kft_pkg::clip64(rnd >>> FRAC_BITS);
        rem_sh   = {rem_reg, dvd_reg[DW-1]};
        ge       = rem_sh >= {1'b0, dmag_reg};
        rem_new  = ge ? 32'(rem_sh - {1'b0, dmag_reg}) : rem_sh[31:0];
        dvd_new  = {dvd_reg[DW-2:0], ge};
        q64      = 64'(dvd_new);
        nmag     = req.a[31] ? 32'(-req.a) : 32'(req.a);
        bmag     = req.b[31] ? 32'(-req.b) : 32'(req.b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ALU_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (st_reg)
                ALU_IDLE: begin
                    if (req.start) begin
                        unique case (req.op) inside
                            kft_pkg::OP_ADD, kft_pkg::OP_SUB: begin
                                res_reg  <= sum_clip.val;
                                sat_reg  <= sum_clip.sat;
                                done_reg <= 1'b1;
                            end
                            kft_pkg::OP_MUL: begin
                                prod_reg <= prod;
                                st_reg   <= ALU_MUL;
                            end
                            kft_pkg::OP_DIV: begin
                                if (req.b == 32'sd0) begin
                                    res_reg  <= 32'sd0;
                                    sat_reg  <= 1'b1;
                                    done_reg <= 1'b1;
                                end else begin
                                    dvd_reg  <= {nmag, {FRAC_BITS{1'b0}}};
                                    dmag_reg <= bmag;
                                    rem_reg  <= 32'd0;
                                    neg_reg  <= req.a[31] ^ req.b[31];
                                    cnt_reg  <= CW'(DW);
                                    st_reg   <= ALU_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ALU_MUL: begin
                    res_reg  <= mul_clip.val;
                    sat_reg  <= mul_clip.sat;
                    done_reg <= 1'b1;
                    st_reg   <= ALU_IDLE;
                end
                ALU_DIV: begin
                    rem_reg <= rem_new;
                    dvd_reg <= dvd_new;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        if (neg_reg) begin
                            if (q64 > 64'h80000000) begin
                                res_reg <= 32'sh80000000;
                                sat_reg <= 1'b1;
                            end else begin
                                res_reg <= 32'(-q64);
                                sat_reg <= 1'b0;
                            end
                        end else begin
                            if (q64 > 64'h7fffffff) begin
                                res_reg <= 32'sh7fffffff;
                                sat_reg <= 1'b1;
                            end else begin
                                res_reg <= q64[31:0];
                                sat_reg <= 1'b0;
                            end
                        end
                        done_reg <= 1'b1;
                        st_reg   <= ALU_IDLE;
                    end
                end
                default: st_reg <= ALU_IDLE;
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;
    assign rsp.sat    = sat_reg;

endmodule
`default_nettype wire

@@ rtl/kft_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kft_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module kft_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_tvalid,
    input wire logic           s_tready,
    input wire logic           m_tvalid,
    input wire logic           m_tready,
    input wire logic [6*32-1:0] m_tdata,
    input wire logic           m_tuser
);

    // hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // drop ready while a word is at work
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // no word is taken as the clearing pass after reset begins
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clearing pass");

endmodule

bind three_axis_kalman_tracker kft_checker u_kft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
